// File: sv/mf3_pkg.sv
package mf3_pkg;

    localparam int PIX_W        = 8;
    localparam int WIDTH_CFG_W  = 11;
    localparam int HEIGHT_W     = 12;
    // rows up to two past the frame are counted while flushing
    localparam int ROW_W        = HEIGHT_W + 1;
    localparam int CFG_DATA_W   = 12;
    localparam int CFG_IDX_W    = 1;
    localparam int MIN_DIM      = 3;
    localparam int WIDTH_RESET  = 640;
    localparam int HEIGHT_RESET = 480;
    localparam int QUEUE_DEPTH  = 4;
    localparam int OUT_DEPTH    = 8;

    typedef logic [PIX_W-1:0]     t_pix;
    // window indexed [row][col], row 0 is the oldest line, col 2 the newest column
    typedef t_pix [2:0][2:0]      t_win;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx REG_FRAME_WIDTH  = 1'd0;
    localparam t_cfg_idx REG_FRAME_HEIGHT = 1'd1;

    typedef struct packed {
        logic flush;   // flush word that emits the last result of the frame
        logic col0;    // first column of a row
        logic r_ge1;   // at least one row above exists
        logic r_ge2;   // at least two rows above exist
    } t_flags;

    function automatic t_pix min2(input t_pix a, input t_pix b);
        return (a < b) ? a : b;
    endfunction

    function automatic t_pix max2(input t_pix a, input t_pix b);
        return (a > b) ? a : b;
    endfunction

    function automatic t_pix med3(input t_pix a, input t_pix b, input t_pix c);
        return max2(min2(a, b), min2(max2(a, b), c));
    endfunction

endpackage

// File: sv/median_filter_3x3.sv
// 3x3 median filter over a zero-padded 8-bit grayscale frame.
// Input stream s_axis: one pixel per word in raster order; tuser carries the
// pad flag, which is not looked at: the word's place in the frame decides
// whether it is a pixel or a flush word. After the frame_width*frame_height
// pixels, send frame_width+1 more words to flush the last results.
// Output stream m_axis: one median per frame position, in raster order;
// tlast marks the last result of the frame, after which a new frame starts.
// A result belongs to the centre pixel one row plus one word earlier; the word
// that completes it passes the input queue, the line-store read stage, the window
// stage and the median stages into the result buffer before it is offered on m_axis.
// While m_axis_tready is high, throughput is one word per cycle on both sides;
// the line store is one dual-port memory of MAX_WIDTH entries, read and written at most once per word.
// The front classifies words into a 4-deep queue; the back holds an 8-deep
// result buffer. When m_axis_tready is low the buffer fills, the back stops
// taking from the queue, and s_axis_tready drops once the queue is full.
// Configuration (frame_width, frame_height) is written through i_cfg_we, by
// the user only while the block is idle; the block does not enforce it.
// Synchronous reset restores 640x480 and empties all queues; the line store needs no clearing.
module median_filter_3x3 #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [7:0]                      s_axis_tdata,   // [7:0] pixel
    input  logic                            s_axis_tuser,   // [0] pad
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [7:0]                      m_axis_tdata,   // [7:0] filtered
    output logic                            m_axis_tlast,
    input  logic                            i_cfg_we,
    input  mf3_pkg::t_cfg_idx               i_cfg_idx,
    input  logic [mf3_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import mf3_pkg::*;

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int QW    = COL_W + PIX_W + $bits(t_flags);
    localparam int QCW   = $clog2(QUEUE_DEPTH + 1);

    logic             s_accept;
    logic             q_push, q_pop, q_empty, q_full;
    logic [QCW-1:0]   q_count;
    logic [QW-1:0]    q_wdata, q_rdata;
    logic [COL_W-1:0] f_col, b_col;
    t_pix             f_pix, b_pix;
    t_flags           f_flags, b_flags;

    assign q_full   = (q_count == QCW'(QUEUE_DEPTH));
    assign s_accept = s_axis_tvalid && s_axis_tready;

    mf3_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (s_axis_tvalid),
        .o_ready    (s_axis_tready),
        .i_pixel    (s_axis_tdata),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_q_full   (q_full),
        .o_push     (q_push),
        .o_col      (f_col),
        .o_pix      (f_pix),
        .o_flags    (f_flags)
    );

    assign q_wdata = {f_col, f_pix, f_flags};

    mf3_fifo #(
        .WIDTH (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wdata),
        .i_pop   (q_pop),
        .o_data  (q_rdata),
        .o_empty (q_empty),
        .o_count (q_count)
    );

    assign {b_col, b_pix, b_flags} = q_rdata;

    mf3_back #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_col     (b_col),
        .i_pix     (b_pix),
        .i_flags   (b_flags),
        .o_q_pop   (q_pop),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_data    (m_axis_tdata),
        .o_last    (m_axis_tlast)
    );

    a_out_idle_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    a_pop_needs_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> (q_count != '0))
        else $error("back took a word from an empty queue");

    a_queue_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_accept && !q_pop) |=> (q_count == $past(q_count) + QCW'(1)))
        else $error("queue lost an accepted word");

endmodule

// File: sv/mf3_fifo.sv
module mf3_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  logic [WIDTH-1:0]           i_data,
    input  logic                       i_pop,
    output logic [WIDTH-1:0]           o_data,
    output logic                       o_empty,
    output logic [$clog2(DEPTH+1)-1:0] o_count
);
    localparam int PW    = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wp, n_wp;
    logic [PW-1:0]    r_rp, n_rp;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             do_push;
    logic             do_pop;

    assign do_push = i_push && (r_cnt != CNT_W'(DEPTH));
    assign do_pop  = i_pop && (r_cnt != '0);

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (do_push) begin
            n_wp = (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + PW'(1);
        end
        if (do_pop) begin
            n_rp = (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + PW'(1);
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    assign o_data  = r_mem[r_rp];
    assign o_empty = (r_cnt == '0);
    assign o_count = r_cnt;

endmodule

// File: sv/mf3_front.sv
module mf3_front #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  mf3_pkg::t_pix                    i_pixel,
    input  logic                             i_cfg_we,
    input  mf3_pkg::t_cfg_idx                i_cfg_idx,
    input  logic [mf3_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                             i_q_full,
    output logic                             o_push,
    output logic [$clog2(MAX_WIDTH)-1:0]     o_col,
    output mf3_pkg::t_pix                    o_pix,
    output mf3_pkg::t_flags                  o_flags
);
    import mf3_pkg::*;

    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int WW        = COL_W + 1;
    localparam int WIDTH_RST = (WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH : WIDTH_RESET;

    logic [WW-1:0]       r_width;
    logic [HEIGHT_W-1:0] r_height;
    logic [COL_W-1:0]    r_col, n_col;
    logic [ROW_W-1:0]    r_row, n_row;

    logic [31:0]         w_req;
    logic [WW-1:0]       w_clamp;
    logic [HEIGHT_W-1:0] h_req;
    logic [HEIGHT_W-1:0] h_clamp;
    logic [ROW_W-1:0]    hp1;
    logic                restart;
    logic [COL_W-1:0]    c_eff;
    logic [ROW_W-1:0]    r_eff;
    logic [WW-1:0]       c_inc;

    // clamp register writes into their legal range
    always_comb begin
        w_req = 32'(i_cfg_data[WIDTH_CFG_W-1:0]);
        if (w_req < 32'(MIN_DIM)) begin
            w_clamp = WW'(MIN_DIM);
        end else if (w_req > 32'(MAX_WIDTH)) begin
            w_clamp = WW'(MAX_WIDTH);
        end else begin
            w_clamp = WW'(w_req);
        end
        h_req   = i_cfg_data[HEIGHT_W-1:0];
        h_clamp = (h_req < HEIGHT_W'(MIN_DIM)) ? HEIGHT_W'(MIN_DIM) : h_req;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WW'(WIDTH_RST);
            r_height <= HEIGHT_W'(HEIGHT_RESET);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_FRAME_WIDTH:  r_width  <= w_clamp;
                REG_FRAME_HEIGHT: r_height <= h_clamp;
                default: ;
            endcase
        end
    end

    // classify the word by its place in the frame
    always_comb begin
        hp1     = ROW_W'(r_height) + ROW_W'(1);
        restart = (WW'(r_col) >= r_width) || (r_row > hp1);
        c_eff   = restart ? '0 : r_col;
        r_eff   = restart ? '0 : r_row;

        o_flags.flush = (r_eff == hp1);
        o_flags.col0  = (c_eff == '0);
        o_flags.r_ge1 = (r_eff != '0);
        o_flags.r_ge2 = (r_eff >= ROW_W'(2));
        o_col         = c_eff;
        o_pix         = (r_eff < ROW_W'(r_height)) ? i_pixel : '0;

        c_inc = WW'(c_eff) + WW'(1);
        if (o_flags.flush) begin
            n_col = '0;
            n_row = '0;
        end else if (c_inc >= r_width) begin
            n_col = '0;
            n_row = r_eff + ROW_W'(1);
        end else begin
            n_col = c_inc[COL_W-1:0];
            n_row = r_eff;
        end
    end

    assign o_ready = !i_q_full;
    assign o_push  = i_valid && !i_q_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (o_push) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

endmodule

// File: sv/mf3_median.sv
module mf3_median (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_vld,
    input  mf3_pkg::t_win   i_win,
    input  logic            i_eof,
    output logic            o_vld,
    output mf3_pkg::t_pix   o_pix,
    output logic            o_eof,
    output logic [1:0]      o_busy
);
    import mf3_pkg::*;

    t_pix [2:0] n_lo, n_md, n_hi;
    t_pix [2:0] r_lo, r_md, r_hi;
    logic       r_s1_vld, r_s2_vld;
    logic       r_s1_eof, r_s2_eof;
    t_pix       r_lo_max, r_md_med, r_hi_min;

    // sort each column
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            n_lo[c] = min2(min2(i_win[0][c], i_win[1][c]), i_win[2][c]);
            n_hi[c] = max2(max2(i_win[0][c], i_win[1][c]), i_win[2][c]);
            n_md[c] = med3(i_win[0][c], i_win[1][c], i_win[2][c]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
        end else begin
            r_s1_vld <= i_vld;
            r_s2_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lo     <= n_lo;
        r_md     <= n_md;
        r_hi     <= n_hi;
        r_s1_eof <= i_eof;
        // largest low, middle middle, smallest high
        r_lo_max <= max2(max2(r_lo[0], r_lo[1]), r_lo[2]);
        r_md_med <= med3(r_md[0], r_md[1], r_md[2]);
        r_hi_min <= min2(min2(r_hi[0], r_hi[1]), r_hi[2]);
        r_s2_eof <= r_s1_eof;
    end

    assign o_vld  = r_s2_vld;
    assign o_pix  = med3(r_lo_max, r_md_med, r_hi_min);
    assign o_eof  = r_s2_eof;
    assign o_busy = 2'(r_s1_vld) + 2'(r_s2_vld);

endmodule

// File: sv/mf3_back.sv
module mf3_back #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_q_empty,
    input  logic [$clog2(MAX_WIDTH)-1:0]  i_col,
    input  mf3_pkg::t_pix                 i_pix,
    input  mf3_pkg::t_flags               i_flags,
    output logic                          o_q_pop,
    output logic                          o_valid,
    input  logic                          i_ready,
    output mf3_pkg::t_pix                 o_data,
    output logic                          o_last
);
    import mf3_pkg::*;

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int OCW   = $clog2(OUT_DEPTH + 1);
    localparam int SUM_W = OCW + 1;

    // each entry holds {two rows above, one row above}
    logic [2*PIX_W-1:0] r_line [MAX_WIDTH];
    logic [2*PIX_W-1:0] r_rd;

    logic               r_a_vld;
    logic [COL_W-1:0]   r_a_col;
    t_pix               r_a_pix;
    t_flags             r_a_flags;

    t_win               r_win, n_win, edge_win;
    t_pix               above, top, mid;
    logic               a_we;

    logic               n_b_vld, n_b_eof;
    t_win               n_b_win;
    logic               r_b_vld, r_b_eof;
    t_win               r_b_win;

    logic               med_vld, med_eof;
    t_pix               med_pix;
    logic [1:0]         med_busy;
    logic [2:0]         inflight;
    logic [OCW-1:0]     out_cnt;
    logic               out_empty;
    logic [PIX_W:0]     out_word;

    assign inflight = 3'(r_a_vld) + 3'(r_b_vld) + 3'(med_busy);
    // reserve an output slot for every word in flight
    assign o_q_pop  = !i_q_empty
                   && ((SUM_W'(out_cnt) + SUM_W'(inflight)) < SUM_W'(OUT_DEPTH));

    always_ff @(posedge i_clk) begin
        r_rd <= r_line[i_col];
        if (a_we) begin
            r_line[r_a_col] <= {above, r_a_pix};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
        end else begin
            r_a_vld <= o_q_pop;
            r_b_vld <= n_b_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_col   <= i_col;
        r_a_pix   <= i_pix;
        r_a_flags <= i_flags;
        r_b_win   <= n_b_win;
        r_b_eof   <= n_b_eof;
        if (a_we) begin
            r_win <= n_win;
        end
    end

    always_comb begin
        above = r_rd[PIX_W-1:0];
        top   = r_a_flags.r_ge2 ? r_rd[2*PIX_W-1:PIX_W] : '0;
        mid   = r_a_flags.r_ge1 ? above : '0;
        a_we  = r_a_vld && !r_a_flags.flush;

        // right-edge neighborhood: old columns 1 and 2 with a zero column
        for (int r = 0; r < 3; r++) begin
            edge_win[r][0] = '0;
            edge_win[r][1] = r_win[r][1];
            edge_win[r][2] = r_win[r][2];
            if (r_a_flags.col0) begin
                n_win[r][0] = '0;
                n_win[r][1] = '0;
            end else begin
                n_win[r][0] = r_win[r][1];
                n_win[r][1] = r_win[r][2];
            end
        end
        n_win[0][2] = top;
        n_win[1][2] = mid;
        n_win[2][2] = r_a_pix;

        n_b_eof = 1'b0;
        if (r_a_flags.flush) begin
            n_b_vld = r_a_vld;
            n_b_win = edge_win;
            n_b_eof = 1'b1;
        end else if (r_a_flags.col0) begin
            n_b_vld = r_a_vld && r_a_flags.r_ge2;
            n_b_win = edge_win;
        end else begin
            n_b_vld = r_a_vld && r_a_flags.r_ge1;
            n_b_win = n_win;
        end
    end

    mf3_median u_median (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_b_vld),
        .i_win   (r_b_win),
        .i_eof   (r_b_eof),
        .o_vld   (med_vld),
        .o_pix   (med_pix),
        .o_eof   (med_eof),
        .o_busy  (med_busy)
    );

    mf3_fifo #(
        .WIDTH (PIX_W + 1),
        .DEPTH (OUT_DEPTH)
    ) u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (med_vld),
        .i_data  ({med_eof, med_pix}),
        .i_pop   (o_valid && i_ready),
        .o_data  (out_word),
        .o_empty (out_empty),
        .o_count (out_cnt)
    );

    assign o_valid = !out_empty;
    assign o_data  = out_word[PIX_W-1:0];
    assign o_last  = out_word[PIX_W];

endmodule

// File: sim/median_check.sv
module median_check (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    input  logic                           s_axis_tready,
    input  logic [7:0]                     s_axis_tdata,   // [7:0] pixel
    input  logic                           s_axis_tuser,   // [0] pad
    input  logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    input  logic [7:0]                     m_axis_tdata,   // [7:0] filtered
    input  logic                           m_axis_tlast,
    input  logic                           i_cfg_we,
    input  mf3_pkg::t_cfg_idx              i_cfg_idx,
    input  logic [mf3_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int                             o_mismatches,
    output int                             o_backlog,
    output int                             o_medians,
    output int                             o_frame_ends
);
    timeunit 1ns;
    timeprecision 1ps;

    import mf3_pkg::*;

    localparam int LINE_MAX   = 1024;
    localparam int HEIGHT_MAX = 4095;

    typedef struct packed {
        t_pix filtered;
        logic frame_end;
    } t_median;

    t_median medians_due[$];

    t_pix above[LINE_MAX];
    t_pix two_above[LINE_MAX];
    t_win win;
    int   frame_w;
    int   frame_h;
    int   col;
    int   row;
    int   mismatches;
    int   medians;
    int   frame_ends;

    function automatic t_pix middle_of_nine(input t_pix v[9]);
        t_pix s[9];
        t_pix x;
        int   j;
        s = v;
        for (int i = 1; i < 9; i++) begin
            x = s[i];
            j = i;
            while (j > 0 && s[j-1] > x) begin
                s[j] = s[j-1];
                j--;
            end
            s[j] = x;
        end
        return s[4];
    endfunction

    // right edge: the two newest columns plus three zero neighbors
    function automatic t_pix edge_median();
        t_pix v[9];
        for (int i = 0; i < 3; i++) begin
            v[i]         = '0;
            v[3 + 2*i]   = win[i][1];
            v[3 + 2*i+1] = win[i][2];
        end
        return middle_of_nine(v);
    endfunction

    function automatic t_pix full_median();
        t_pix v[9];
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                v[3*i + j] = win[i][j];
        return middle_of_nine(v);
    endfunction

    task automatic restart_frame();
        win = '0;
        col = 0;
        row = 0;
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] data);
        int v;
        if (idx == REG_FRAME_WIDTH) begin
            v = int'(data[WIDTH_CFG_W-1:0]);
            frame_w = (v < MIN_DIM) ? MIN_DIM : (v > LINE_MAX) ? LINE_MAX : v;
        end else if (idx == REG_FRAME_HEIGHT) begin
            v = int'(data[HEIGHT_W-1:0]);
            frame_h = (v < MIN_DIM) ? MIN_DIM : (v > HEIGHT_MAX) ? HEIGHT_MAX : v;
        end
    endtask

    task automatic filter_step(input t_pix pix);
        t_pix v;
        t_pix top;
        t_pix mid;
        if (col >= frame_w || row > frame_h + 1)
            restart_frame();
        if (row == frame_h + 1) begin
            medians_due.push_back('{edge_median(), 1'b1});
            restart_frame();
            return;
        end
        v   = (row < frame_h) ? pix : '0;
        top = (row >= 2) ? two_above[col] : '0;
        mid = (row >= 1) ? above[col] : '0;
        two_above[col] = above[col];
        above[col]     = v;
        if (col == 0) begin
            if (row >= 2)
                medians_due.push_back('{edge_median(), 1'b0});
            for (int i = 0; i < 3; i++) begin
                win[i][0] = '0;
                win[i][1] = '0;
            end
        end else begin
            for (int i = 0; i < 3; i++) begin
                win[i][0] = win[i][1];
                win[i][1] = win[i][2];
            end
        end
        win[0][2] = top;
        win[1][2] = mid;
        win[2][2] = v;
        if (col >= 1 && row >= 1)
            medians_due.push_back('{full_median(), 1'b0});
        col++;
        if (col >= frame_w) begin
            col = 0;
            row++;
        end
    endtask

    task automatic check_median(input t_pix got, input logic got_end);
        t_median want;
        if (medians_due.size() == 0) begin
            $display("%0t: median %0d (end %0b) arrived with none expected",
                     $time, got, got_end);
            mismatches++;
            return;
        end
        want = medians_due.pop_front();
        medians++;
        if (got_end === 1'b1)
            frame_ends++;
        if (got !== want.filtered) begin
            $display("%0t: filtered mismatch, expected %0d, actual %0d",
                     $time, want.filtered, got);
            mismatches++;
        end
        if (got_end !== want.frame_end) begin
            $display("%0t: end_of_frame mismatch, expected %0b, actual %0b",
                     $time, want.frame_end, got_end);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            frame_w = WIDTH_RESET;
            frame_h = HEIGHT_RESET;
            for (int i = 0; i < LINE_MAX; i++) begin
                above[i]     = '0;
                two_above[i] = '0;
            end
            restart_frame();
            medians_due.delete();
            mismatches = 0;
            medians    = 0;
            frame_ends = 0;
        end else begin
            // drain first: a word accepted at this edge cannot leave at it
            if (m_axis_tvalid && m_axis_tready)
                check_median(m_axis_tdata, m_axis_tlast);
            if (i_cfg_we)
                write_reg(i_cfg_idx, i_cfg_data);
            if (s_axis_tvalid && s_axis_tready)
                filter_step(s_axis_tdata);
        end
        o_backlog    <= medians_due.size();
        o_mismatches <= mismatches;
        o_medians    <= medians;
        o_frame_ends <= frame_ends;
    end

endmodule

// File: sim/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import mf3_pkg::*;

    localparam int SETTLE       = 24;
    localparam int RANDOM_WORDS = 150;
    localparam int CALM_AFTER   = 100;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [7:0]            s_axis_tdata  = '0;   // [7:0] pixel
    logic                  s_axis_tuser  = 1'b0; // [0] pad
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b1;
    logic [7:0]            m_axis_tdata;         // [7:0] filtered
    logic                  m_axis_tlast;
    logic                  i_cfg_we      = 1'b0;
    t_cfg_idx              i_cfg_idx     = REG_FRAME_WIDTH;
    logic [CFG_DATA_W-1:0] i_cfg_data    = '0;

    int mismatches;
    int backlog;
    int medians;
    int frame_ends;

    bit calm        = 1'b0;
    int stall_left  = 0;
    int words_sent  = 0;
    int frame_setups = 0;

    median_filter_3x3 uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    median_check checker_i (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .o_mismatches  (mismatches),
        .o_backlog     (backlog),
        .o_medians     (medians),
        .o_frame_ends  (frame_ends)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("Verification failed");
        $finish;
    end

    // sink side: random stall bursts, none once the run goes calm
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            m_axis_tready <= 1'b0;
            stall_left    <= stall_left - 1;
        end else if (!calm && i_rst_n && $urandom_range(0, 5) == 0) begin
            m_axis_tready <= 1'b0;
            stall_left    <= $urandom_range(0, 6);
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    function automatic t_pix pick_pixel();
        case ($urandom_range(0, 3))
            0:       return $urandom_range(0, 1) ? 8'hFF : 8'h00;
            1:       return t_pix'($urandom_range(100, 103));
            default: return t_pix'($urandom_range(0, 255));
        endcase
    endfunction

    // call it in step with the clock; returns when the word is accepted, with tvalid still high
    task automatic send_word(input t_pix pix, input logic pad);
        int gap;
        if (!calm && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 7);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pix;
        s_axis_tuser  <= pad;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        words_sent++;
    endtask

    task automatic stop_words();
        s_axis_tvalid <= 1'b0;
    endtask

    // wait past the last accept so a push there is visible in backlog
    task automatic wait_idle();
        @(posedge i_clk);
        while (backlog != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic program_frame(input logic [CFG_DATA_W-1:0] w_raw,
                                 input logic [CFG_DATA_W-1:0] h_raw);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= REG_FRAME_WIDTH;
        i_cfg_data <= w_raw;
        @(posedge i_clk);
        i_cfg_idx  <= REG_FRAME_HEIGHT;
        i_cfg_data <= h_raw;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        frame_setups++;
    endtask

    // send the first `count` words of a w x h frame plus its flush
    task automatic stream_frame(input int w, input int h, input int count);
        for (int n = 0; n < count; n++) begin
            if (n < w * h)
                send_word(pick_pixel(), $urandom_range(0, 7) == 0);
            else if ($urandom_range(0, 4) == 0)
                send_word(pick_pixel(), 1'b0);   // stray pixel in the flush, dropped
            else
                send_word(pick_pixel(), 1'b1);
        end
        stop_words();
    endtask

    initial begin
        t_pix ring[9];
        int   w;
        int   h;
        int   total;
        int   count;
        int   random_start;
        logic [CFG_DATA_W-1:0] w_raw;
        logic [CFG_DATA_W-1:0] h_raw;

        ring = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // part of a first row at the 640x480 reset geometry, then shrink mid-frame
        send_word(8'h00, 1'b0);
        send_word(8'hFF, 1'b1);
        send_word(8'h55, 1'b0);
        send_word(8'hAA, 1'b1);
        send_word(8'h01, 1'b0);
        send_word(8'h80, 1'b1);
        stop_words();
        wait_idle();
        program_frame(12'd2, 12'd0);   // both clamp up to 3

        // smallest frame: bright ring around a dark center, stray pixel in the flush
        for (int i = 0; i < 9; i++)
            send_word(ring[i], i[0]);
        send_word(8'h12, 1'b1);
        send_word(8'hAB, 1'b0);
        send_word(8'h34, 1'b1);
        send_word(8'h56, 1'b1);
        stop_words();
        wait_idle();

        // widest line, with bit 11 set on the width write: one full row, then the
        // start of the next so both line halves hold pixels for the narrow frames
        program_frame(12'hFFF, 12'd3);
        stream_frame(1024, 3, 1024 + 64);
        wait_idle();

        // tallest frame, cut short, then a smaller height restarts it
        program_frame(12'd3, 12'd4095);
        stream_frame(3, 4095, 36);
        wait_idle();
        program_frame(12'd3, 12'd5);
        stream_frame(3, 5, 3 * 5 + 4);
        wait_idle();

        // narrow a frame mid-row without forcing a restart
        program_frame(12'd8, 12'd6);
        stream_frame(8, 6, 8 * 3 + 2);
        wait_idle();
        program_frame(12'd5, 12'd4);
        stream_frame(5, 4, 9);
        wait_idle();

        random_start = words_sent;
        while (words_sent - random_start < RANDOM_WORDS) begin
            w = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 64) : $urandom_range(3, 12);
            h = $urandom_range(3, 8);
            w_raw = CFG_DATA_W'(w);
            h_raw = CFG_DATA_W'(h);
            if ($urandom_range(0, 9) == 0) begin
                w     = MIN_DIM;
                w_raw = CFG_DATA_W'($urandom_range(0, 2));
            end
            if ($urandom_range(0, 9) == 0) begin
                h     = MIN_DIM;
                h_raw = CFG_DATA_W'($urandom_range(0, 2));
            end
            total = w * h + w + 1;
            count = ($urandom_range(0, 5) == 0) ? $urandom_range(1, total - 1) : total;
            if (words_sent - random_start > CALM_AFTER)
                calm = 1'b1;
            program_frame(w_raw, h_raw);
            stream_frame(w, h, count);
            wait_idle();
        end

        // close any frame left open by a cut sequence
        program_frame(12'd3, 12'd3);
        stream_frame(3, 3, 13);
        wait_idle();

        $display("Sent %0d words over %0d frame setups (widths 3 to 1024, heights 3 to 4095)",
                 words_sent, frame_setups);
        $display("Checked %0d medians, %0d of them frame ends, with stalls on both sides",
                 medians, frame_ends);
        if (mismatches == 0 && backlog == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// File: median_filter_3x3.f
sv/mf3_pkg.sv
sv/mf3_fifo.sv
sv/mf3_front.sv
sv/mf3_median.sv
sv/mf3_back.sv
sv/median_filter_3x3.sv
sim/median_check.sv
sim/tb_top.sv
